@@ design/qvr_pkg.sv @@
package qvr_pkg;

    // Fixed field widths.
    localparam int DATA_W       = 32;
    localparam int PROD_W       = 2 * DATA_W;
    // A diagonal entry sums four products and an off-diagonal entry doubles a
    // sum of two, so both need two guard bits above a product.
    localparam int SUM_W        = PROD_W + 2;
    localparam int FRAC_BITS_DEF = 30;
    localparam int N_STAGES     = 7;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] quat_w;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
    } t_quat_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] rot_x;
        logic signed [DATA_W-1:0] rot_y;
        logic signed [DATA_W-1:0] rot_z;
        logic                     saturated;
    } t_rot_out;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } t_vec;

    // The ten distinct products of quaternion components.
    typedef struct packed {
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] ww;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] zw;
        logic signed [PROD_W-1:0] xz;
        logic signed [PROD_W-1:0] yw;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] xw;
    } t_prods;

endpackage

@@ design/qvr_prod.sv @@
module qvr_prod (
    input  logic              i_clk,
    input  logic              i_en,
    input  qvr_pkg::t_quat_in i_data,
    output qvr_pkg::t_prods   o_prod,
    output qvr_pkg::t_vec     o_vec
);

    localparam int PW = qvr_pkg::PROD_W;

    qvr_pkg::t_prods n_prod;
    qvr_pkg::t_prods r_prod;
    qvr_pkg::t_vec   n_vec;
    qvr_pkg::t_vec   r_vec;

    always_comb begin
        n_prod.xx = PW'(i_data.quat_x) * PW'(i_data.quat_x);
        n_prod.yy = PW'(i_data.quat_y) * PW'(i_data.quat_y);
        n_prod.zz = PW'(i_data.quat_z) * PW'(i_data.quat_z);
        n_prod.ww = PW'(i_data.quat_w) * PW'(i_data.quat_w);
        n_prod.xy = PW'(i_data.quat_x) * PW'(i_data.quat_y);
        n_prod.zw = PW'(i_data.quat_z) * PW'(i_data.quat_w);
        n_prod.xz = PW'(i_data.quat_x) * PW'(i_data.quat_z);
        n_prod.yw = PW'(i_data.quat_y) * PW'(i_data.quat_w);
        n_prod.yz = PW'(i_data.quat_y) * PW'(i_data.quat_z);
        n_prod.xw = PW'(i_data.quat_x) * PW'(i_data.quat_w);
        n_vec.x   = i_data.vec_x;
        n_vec.y   = i_data.vec_y;
        n_vec.z   = i_data.vec_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_vec  <= n_vec;
        end
    end

    assign o_prod = r_prod;
    assign o_vec  = r_vec;

endmodule

@@ design/qvr_dcm.sv @@
module qvr_dcm #(
    parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF,
    localparam int EW       = qvr_pkg::SUM_W - FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic [1:0]           i_en,
    input  qvr_pkg::t_prods      i_prod,
    input  qvr_pkg::t_vec        i_vec,
    output logic signed [EW-1:0] o_ent [9],
    output qvr_pkg::t_vec        o_vec
);

    localparam int SW = qvr_pkg::SUM_W;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);

    logic signed [SW-1:0] xx, yy, zz, ww, xy, zw, xz, yw, yz, xw;
    logic signed [SW-1:0] n_sum [9];
    logic signed [SW-1:0] r_sum [9];
    logic signed [EW-1:0] n_ent [9];
    logic signed [EW-1:0] r_ent [9];
    qvr_pkg::t_vec        r_vec_s2;
    qvr_pkg::t_vec        r_vec_s3;

    assign xx = SW'(i_prod.xx);
    assign yy = SW'(i_prod.yy);
    assign zz = SW'(i_prod.zz);
    assign ww = SW'(i_prod.ww);
    assign xy = SW'(i_prod.xy);
    assign zw = SW'(i_prod.zw);
    assign xz = SW'(i_prod.xz);
    assign yw = SW'(i_prod.yw);
    assign yz = SW'(i_prod.yz);
    assign xw = SW'(i_prod.xw);

    // Row-major entries; the off-diagonal signs follow the transposed convention.
    assign n_sum[0] = ww + xx - yy - zz;
    assign n_sum[1] = (xy + zw) <<< 1;
    assign n_sum[2] = (xz - yw) <<< 1;
    assign n_sum[3] = (xy - zw) <<< 1;
    assign n_sum[4] = ww - xx + yy - zz;
    assign n_sum[5] = (yz + xw) <<< 1;
    assign n_sum[6] = (xz + yw) <<< 1;
    assign n_sum[7] = (yz - xw) <<< 1;
    assign n_sum[8] = ww - xx - yy + zz;

    for (genvar k = 0; k < 9; k++) begin : g_round
        logic signed [SW-1:0] biased;
        assign biased   = r_sum[k] + HALF;
        assign n_ent[k] = EW'(biased >>> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sum    <= n_sum;
            r_vec_s2 <= i_vec;
        end
        if (i_en[1]) begin
            r_ent    <= n_ent;
            r_vec_s3 <= r_vec_s2;
        end
    end

    assign o_ent = r_ent;
    assign o_vec = r_vec_s3;

endmodule

@@ design/qvr_matvec.sv @@
module qvr_matvec #(
    parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF,
    localparam int EW       = qvr_pkg::SUM_W - FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic [3:0]           i_en,
    input  logic signed [EW-1:0] i_ent [9],
    input  qvr_pkg::t_vec        i_vec,
    output qvr_pkg::t_rot_out    o_data
);

    localparam int DW = qvr_pkg::DATA_W;
    localparam int LW = 2 * DW + 1;   // unsigned low half times a signed component
    localparam int PW = EW + DW;      // full entry-by-component product
    localparam int AW = PW + 2;       // sum of three products plus rounding bias
    localparam int RW = AW - FRAC_BITS;
    localparam logic signed [AW-1:0] HALF    = AW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

    logic signed [DW-1:0] vec_a [3];
    logic signed [LW-1:0] n_lo  [9];
    logic signed [LW-1:0] r_lo  [9];
    logic signed [EW-1:0] n_hi  [9];
    logic signed [EW-1:0] r_hi  [9];
    logic signed [PW-1:0] n_prod [9];
    logic signed [PW-1:0] r_prod [9];
    logic signed [AW-1:0] n_acc [3];
    logic signed [AW-1:0] r_acc [3];
    logic signed [DW-1:0] comp  [3];
    logic [2:0]           clip;
    qvr_pkg::t_rot_out    n_out;
    qvr_pkg::t_rot_out    r_out;

    assign vec_a[0] = i_vec.x;
    assign vec_a[1] = i_vec.y;
    assign vec_a[2] = i_vec.z;

    // Each entry is split at bit 32 so that no multiplier exceeds 33 by 32 bits.
    for (genvar k = 0; k < 9; k++) begin : g_mul
        assign n_lo[k] = LW'($signed({1'b0, i_ent[k][DW-1:0]})) * LW'(vec_a[k % 3]);
        assign n_hi[k] = EW'($signed(i_ent[k][EW-1:DW])) * EW'(vec_a[k % 3]);
        assign n_prod[k] = (PW'(r_hi[k]) <<< DW) + PW'(r_lo[k]);
    end

    for (genvar i = 0; i < 3; i++) begin : g_row
        logic signed [AW-1:0] shifted;
        logic signed [RW-1:0] rnd;
        logic                 fits;

        assign n_acc[i] = AW'(r_prod[3*i]) + AW'(r_prod[3*i+1]) + AW'(r_prod[3*i+2])
                        + HALF;
        assign shifted  = r_acc[i] >>> FRAC_BITS;
        assign rnd      = RW'(shifted);
        assign fits     = (&rnd[RW-1:DW-1]) | ~(|rnd[RW-1:DW-1]);
        assign clip[i]  = ~fits;
        assign comp[i]  = fits ? rnd[DW-1:0] : (rnd[RW-1] ? SAT_MIN : SAT_MAX);
    end

    always_comb begin
        n_out.rot_x     = comp[0];
        n_out.rot_y     = comp[1];
        n_out.rot_z     = comp[2];
        n_out.saturated = |clip;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_en[1]) begin
            r_prod <= n_prod;
        end
        if (i_en[2]) begin
            r_acc <= n_acc;
        end
        if (i_en[3]) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

@@ design/quaternion_vector_rotate_top.sv @@
// Rotates a 3-vector by the direction-cosine matrix of an unnormalised
// quaternion (x, y, z, scalar w in signed Q1.FRAC_BITS) and returns the three
// components rounded to nearest and saturated to 32 bits, with a flag when any
// of them was clipped. One transfer is taken every clock cycle unless the pipeline
// is full and the output stalls. It has one stage of quaternion products, two
// that sum and round the nine matrix entries, and four that multiply the
// entries by the vector, accumulate the rows, round and saturate. Each stage
// holds only while it is full and the one after it holds, so a stall on the
// output fills empty slots first and only then holds the input.
module quaternion_vector_rotate_top #(
    parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  qvr_pkg::t_quat_in i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output qvr_pkg::t_rot_out o_data
);

    localparam int NS = qvr_pkg::N_STAGES;
    localparam int EW = qvr_pkg::SUM_W - FRAC_BITS;
    localparam logic signed [qvr_pkg::DATA_W-1:0] SAT_MAX = {1'b0, {(qvr_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [qvr_pkg::DATA_W-1:0] SAT_MIN = {1'b1, {(qvr_pkg::DATA_W-1){1'b0}}};

    logic [NS-1:0]        r_vld;
    logic [NS-1:0]        shift_in;
    logic [NS-1:0]        en;
    qvr_pkg::t_prods      prod;
    qvr_pkg::t_vec        vec_s1;
    qvr_pkg::t_vec        vec_s3;
    logic signed [EW-1:0] ent [9];
    logic                 in_xfer;
    logic                 out_xfer;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign shift_in = {r_vld[NS-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= shift_in[k];
                end
            end
        end
    end

    assign o_stall  = !en[0];
    assign o_valid  = r_vld[NS-1];
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = o_valid && !i_stall;

    qvr_prod u_prod (
        .i_clk  (i_clk),
        .i_en   (en[0]),
        .i_data (i_data),
        .o_prod (prod),
        .o_vec  (vec_s1)
    );

    qvr_dcm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dcm (
        .i_clk  (i_clk),
        .i_en   (en[2:1]),
        .i_prod (prod),
        .i_vec  (vec_s1),
        .o_ent  (ent),
        .o_vec  (vec_s3)
    );

    qvr_matvec #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matvec (
        .i_clk  (i_clk),
        .i_en   (en[NS-1:3]),
        .i_ent  (ent),
        .i_vec  (vec_s3),
        .o_data (o_data)
    );

    // The input is held back only when every stage is occupied and the output waits.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input held while the pipeline has an empty slot");

    // Items in flight change only by transfers on the two ports.
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> ($countones(r_vld) == $past($countones(r_vld))
                     + $past(32'(in_xfer)) - $past(32'(out_xfer))))
        else $error("item lost or duplicated inside the pipeline");

    // A clipped result carries a limit value in at least one component.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.saturated) |->
        (o_data.rot_x == SAT_MAX || o_data.rot_x == SAT_MIN ||
         o_data.rot_y == SAT_MAX || o_data.rot_y == SAT_MIN ||
         o_data.rot_z == SAT_MAX || o_data.rot_z == SAT_MIN))
        else $error("saturation flag set without a limit value");

endmodule

@@ sim/tb_quaternion_vector_rotate_top.sv @@
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate_top;

    localparam int DATA_W = qvr_pkg::DATA_W;
    localparam int FRAC = qvr_pkg::FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
    localparam logic signed [127:0] SAT_LO = -128'sd2147483648;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh4000_0000;
    // cos(45 degrees) in Q1.30, for quarter turns.
    localparam logic signed [DATA_W-1:0] Q_HALF_SQRT2 = 32'sd759250125;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    qvr_pkg::t_quat_in i_data = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    qvr_pkg::t_rot_out o_data;

    qvr_pkg::t_rot_out pending_rotations[$];
    int       mismatch_count = 0;
    int       rotations_sent = 0;
    int       rotations_checked = 0;
    int       clipped_seen = 0;
    int       cycle_count = 0;
    bit       source_gaps_on = 1'b1;
    bit       sink_stalls_on = 1'b1;

    quaternion_vector_rotate_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #4 i_clk = ~i_clk;

    // Round to nearest with ties towards plus infinity, then drop the fraction.
    function automatic logic signed [127:0] round_frac(input logic signed [127:0] v);
        return (v + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic qvr_pkg::t_rot_out rotate_vector(input qvr_pkg::t_quat_in d);
        logic signed [127:0] qx, qy, qz, qw;
        logic signed [127:0] xx, yy, zz, ww, xy, zw, xz, yw, yz, xw;
        logic signed [127:0] m [3][3];
        logic signed [127:0] v [3];
        logic signed [127:0] acc;
        logic [DATA_W-1:0]   comp [3];
        qvr_pkg::t_rot_out r;
        qx = signed'(d.quat_x);
        qy = signed'(d.quat_y);
        qz = signed'(d.quat_z);
        qw = signed'(d.quat_w);
        v[0] = signed'(d.vec_x);
        v[1] = signed'(d.vec_y);
        v[2] = signed'(d.vec_z);
        xx = qx * qx; yy = qy * qy; zz = qz * qz; ww = qw * qw;
        xy = qx * qy; zw = qz * qw; xz = qx * qz;
        yw = qy * qw; yz = qy * qz; xw = qx * qw;
        m[0][0] = round_frac(ww + xx - yy - zz);
        m[1][1] = round_frac(ww - xx + yy - zz);
        m[2][2] = round_frac(ww - xx - yy + zz);
        m[0][1] = round_frac((xy + zw) <<< 1);
        m[1][0] = round_frac((xy - zw) <<< 1);
        m[0][2] = round_frac((xz - yw) <<< 1);
        m[2][0] = round_frac((xz + yw) <<< 1);
        m[1][2] = round_frac((yz + xw) <<< 1);
        m[2][1] = round_frac((yz - xw) <<< 1);
        r.saturated = 1'b0;
        for (int i = 0; i < 3; i++) begin
            acc = round_frac(m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2]);
            if (acc > SAT_HI) begin
                acc = SAT_HI;
                r.saturated = 1'b1;
            end else if (acc < SAT_LO) begin
                acc = SAT_LO;
                r.saturated = 1'b1;
            end
            comp[i] = acc[DATA_W-1:0];
        end
        r.rot_x = comp[0];
        r.rot_y = comp[1];
        r.rot_z = comp[2];
        return r;
    endfunction

    function automatic qvr_pkg::t_quat_in make_item(
        input logic signed [DATA_W-1:0] qx, qy, qz, qw, vx, vy, vz
    );
        qvr_pkg::t_quat_in d;
        d.quat_x = qx; d.quat_y = qy; d.quat_z = qz; d.quat_w = qw;
        d.vec_x = vx;  d.vec_y = vy;  d.vec_z = vz;
        return d;
    endfunction

    // Quaternion component of at most one in magnitude, with either sign.
    function automatic logic signed [DATA_W-1:0] unit_component();
        logic signed [DATA_W-1:0] c;
        c = signed'($urandom_range(0, Q_ONE));
        return $urandom_range(1) ? -c : c;
    endfunction

    // Vector component spread over all magnitudes.
    function automatic logic signed [DATA_W-1:0] spread_component();
        logic signed [DATA_W-1:0] c;
        c = signed'($urandom());
        return c >>> $urandom_range(0, 31);
    endfunction

    task automatic send_rotation(input qvr_pkg::t_quat_in d);
        if (source_gaps_on) begin
            while ($urandom_range(99) < 19) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
        pending_rotations.push_back(rotate_vector(d));
        rotations_sent++;
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        wait (pending_rotations.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic test_identity_and_turns();
        send_rotation(make_item(0, 0, 0, 0, Q_MAX, Q_MIN, 1));
        send_rotation(make_item(0, 0, 0, Q_ONE, Q_MAX, Q_MIN, 0));
        send_rotation(make_item(0, 0, 0, Q_ONE, Q_MIN, Q_MAX, -1));
        send_rotation(make_item(0, 0, 0, -Q_ONE, 1, -1, 12345));
        send_rotation(make_item(0, 0, Q_HALF_SQRT2, Q_HALF_SQRT2, Q_ONE, 0, 0));
        send_rotation(make_item(Q_HALF_SQRT2, 0, 0, Q_HALF_SQRT2, 0, Q_ONE, -Q_ONE));
        send_rotation(make_item(0, Q_HALF_SQRT2, 0, -Q_HALF_SQRT2, 7, -Q_ONE, Q_MAX));
        send_rotation(make_item(Q_ONE, 0, 0, 0, 1000, 2000, 3000));
        send_rotation(make_item(0, Q_ONE, 0, 0, Q_MIN, 5, Q_MAX));
    endtask

    task automatic test_rounding_ties();
        // Entries of a single unit of scale 2^-30 put row sums exactly
        // on a half, both positive and negative.
        send_rotation(make_item(0, 0, 0, 32'sd32768, 32'sd536870912,
                                -32'sd536870912, 32'sd1610612736));
        send_rotation(make_item(32'sd16384, 32'sd16384, 0, 0, 32'sd536870912,
                                -32'sd536870912, 3));
        send_rotation(make_item(32'sd16384, 0, -32'sd16384, 0, -32'sd536870911,
                                32'sd536870913, -32'sd536870912));
    endtask

    task automatic test_saturation();
        send_rotation(make_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_rotation(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        send_rotation(make_item(Q_MIN, 0, 0, 0, Q_MAX, Q_MAX, Q_MIN));
        send_rotation(make_item(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        // A scalar part near two scales the vector by four; at most one axis clips.
        send_rotation(make_item(0, 0, 0, Q_MAX, 32'sd536870912, 100, -100));
        send_rotation(make_item(0, 0, 0, Q_MAX, -32'sd536870913, -5, 5));
        send_rotation(make_item(0, 0, 0, Q_MAX, 32'sd536870911, -32'sd536870912, 0));
        send_rotation(make_item(Q_MIN, Q_MAX, 0, Q_MIN, 0, 0, Q_MAX));
    endtask

    task automatic test_random_unit(input int count);
        for (int n = 0; n < count; n++) begin
            send_rotation(make_item(unit_component(), unit_component(),
                                    unit_component(), unit_component(),
                                    spread_component(), spread_component(),
                                    spread_component()));
        end
    endtask

    task automatic test_random_full(input int count);
        for (int n = 0; n < count; n++) begin
            send_rotation(make_item($urandom(), $urandom(), $urandom(), $urandom(),
                                    $urandom(), $urandom(), spread_component()));
        end
    endtask

    task automatic test_drain_pause();
        test_random_unit(40);
        pause_until_drained();
        test_random_full(40);
    endtask

    task automatic test_back_to_back();
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        test_random_unit(300);
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] expected,
                                 input logic [DATA_W-1:0] actual);
        if (actual !== expected) begin
            $error("%s mismatch: expected %0d, actual %0d", name,
                   $signed(expected), $signed(actual));
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= sink_stalls_on ? ($urandom_range(99) < 19) : 1'b0;
    end

    always @(posedge i_clk) begin
        qvr_pkg::t_rot_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rotations.size() == 0) begin
                $error("result transfer with no input outstanding");
                mismatch_count++;
            end else begin
                want = pending_rotations.pop_front();
                compare_field("rot_x", want.rot_x, o_data.rot_x);
                compare_field("rot_y", want.rot_y, o_data.rot_y);
                compare_field("rot_z", want.rot_z, o_data.rot_z);
                compare_field("saturated", DATA_W'(want.saturated),
                              DATA_W'(o_data.saturated));
                rotations_checked++;
                if (want.saturated) clipped_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_rotations.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_and_turns();
        test_rounding_ties();
        test_saturation();
        test_random_unit(700);
        test_drain_pause();
        test_back_to_back();
        test_random_full(500);
        test_random_unit(320);

        i_valid <= 1'b0;
        wait (pending_rotations.size() == 0);
        repeat (qvr_pkg::N_STAGES + 8) @(posedge i_clk);

        $display("Sent %0d quaternion rotations, checked %0d results (%0d clipped).",
                 rotations_sent, rotations_checked, clipped_seen);
        $display("Covered extremes, rounding ties, saturation and random gaps on both sides.");
        if (mismatch_count == 0 && pending_rotations.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
